// ===== design/assert_macros.svh =====
// Assertion macros for the polygon edge plane setup block.
// No dependencies; pulled in by the top level with a bare include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PESU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pesu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PESU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pesu: next-cycle check failed");

`endif

// ===== design/pesu_pkg.sv =====
// Package for the polygon edge plane setup block: widths, opcodes, control structs.
// No dependencies; used by all modules and interfaces of the block.
`timescale 1ns / 1ps

package pesu_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 32;
    localparam int DIST_W  = 40;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 64;
    localparam int REM_W   = 36;
    localparam int ROOT_W  = 32;

    // Operations of the shared compare-subtract unit
    typedef enum logic
    {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } pesu_op_t;

    // Request to the iterative square root / divide unit
    typedef struct packed
    {
        logic     start;
        pesu_op_t op;
    } pesu_iter_ctrl_t;

    // Request to the multiply-accumulate unit
    typedef struct packed
    {
        logic valid;
        logic first;
        logic last;
    } pesu_mac_ctrl_t;

endpackage

// ===== design/pesu_vertex_if.sv =====
// Vertex request channel: valid/ready handshake with one polygon vertex.
// Depends on pesu_pkg for the coordinate width.
`timescale 1ns / 1ps

interface pesu_vertex_if
    import pesu_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

// ===== design/pesu_plane_if.sv =====
// Plane request channel: valid/ready handshake with one edge half-plane.
// Depends on pesu_pkg for the normal and distance widths.
`timescale 1ns / 1ps

interface pesu_plane_if
    import pesu_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [DIST_W-1:0] plane_distance;
    logic                     degenerate_edge;
    logic                     last_plane;

    modport source (output valid, output normal_x, output normal_y, output plane_distance,
                    output degenerate_edge, output last_plane, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input plane_distance,
                    input degenerate_edge, input last_plane, output ready);
endinterface

// ===== design/pesu_iter_unit.sv =====
// Iterative unit: one compare-subtract per cycle, shared by integer square root
// (two radicand bits a step) and restoring division (one numerator bit a step).
// Depends on pesu_pkg.
`timescale 1ns / 1ps

module pesu_iter_unit
    import pesu_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 30
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pesu_iter_ctrl_t       ctrl,
    input  logic [PROD_W-1:0]     operand,
    input  logic [ROOT_W-1:0]     divisor,
    output logic                  done,
    output logic [ROOT_W-1:0]     result
);

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NORMAL_FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    pesu_op_t          op_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [PROD_W-1:0] src_reg;
    logic [ROOT_W-1:0] res_reg;
    logic [ROOT_W-1:0] div_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_next;
    logic [PROD_W-1:0] src_next;
    logic [PROD_W-1:0] num_hi;

    // Shared step: shift in the next digit, compare against the trial, subtract
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh   = {rem_reg[REM_W-3:0], src_reg[PROD_W-1:PROD_W-2]};
            trial    = {2'b00, res_reg, 2'b01};
            src_next = {src_reg[PROD_W-3:0], 2'b00};
        end
        else
        begin
            rem_sh   = {rem_reg[REM_W-2:0], src_reg[PROD_W-1]};
            trial    = {{(REM_W-ROOT_W){1'b0}}, div_reg};
            src_next = {src_reg[PROD_W-2:0], 1'b0};
        end
        ge       = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
    end

    assign num_hi = operand >> DIV_STEPS;

    // Control: busy flag, step count, completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctrl.op == OP_SQRT) ? CNT_W'(SQRT_STEPS - 1)
                                                 : CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one digit per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            op_reg  <= ctrl.op;
            res_reg <= '0;
            div_reg <= divisor;
            if (ctrl.op == OP_SQRT)
            begin
                rem_reg <= '0;
                src_reg <= operand;
            end
            else
            begin
                rem_reg <= num_hi[REM_W-1:0];
                src_reg <= operand << (PROD_W - DIV_STEPS);
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            src_reg <= src_next;
            res_reg <= {res_reg[ROOT_W-2:0], ge};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== design/pesu_mac.sv =====
// Multiply-accumulate unit: registered 32x32 signed product, then a 64-bit sum.
// Depends on pesu_pkg.
`timescale 1ns / 1ps

module pesu_mac
    import pesu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pesu_mac_ctrl_t             ctrl,
    input  logic signed [COORD_W-1:0]  op_a,
    input  logic signed [COORD_W-1:0]  op_b,
    output logic                       done,
    output logic signed [PROD_W-1:0]   acc
);

    logic                     p_valid_reg;
    logic                     p_first_reg;
    logic                     p_last_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;

    // Control: track the product stage and flag the final term
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_first_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ctrl.valid;
            p_first_reg <= ctrl.first;
            p_last_reg  <= ctrl.last;
            done_reg    <= p_valid_reg && p_last_reg;
        end
    end

    // Multiply stage, then accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
        if (p_valid_reg)
        begin
            acc_reg <= (p_first_reg ? '0 : acc_reg) + prod_reg;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ===== design/polygon_edge_plane_setup_unit.sv =====
// Polygon edge plane setup: turns vertices into edge half-planes (normal, distance).
// Depends on pesu_pkg, both channel interfaces, pesu_iter_unit, pesu_mac, assert_macros.svh.
// A zero-length edge goes from the difference step straight to the plane request; any other
// edge passes through the normalize shifts, the squares, the shared square root / divide
// unit and the dot product. A closing vertex that follows others adds a second plane.
// One vertex at a time. Reset clears the sequencer and the polygon state at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module polygon_edge_plane_setup_unit
    import pesu_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 30
)
(
    input  logic           clk,
    input  logic           rst_n,
    pesu_vertex_if.sink    vertex,
    pesu_plane_if.source   plane
);

    typedef enum logic [12:0]
    {
        S_IDLE = 13'b0000000000001,
        S_DIFF = 13'b0000000000010,
        S_NORM = 13'b0000000000100,
        S_SQA  = 13'b0000000001000,
        S_SQB  = 13'b0000000010000,
        S_SQW  = 13'b0000000100000,
        S_SQRT = 13'b0000001000000,
        S_DIVY = 13'b0000010000000,
        S_DIVX = 13'b0000100000000,
        S_DOTA = 13'b0001000000000,
        S_DOTB = 13'b0010000000000,
        S_DOTW = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } state_t;

    localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(1) << (NORMAL_FRAC_BITS - 1);

    state_t state_reg;
    state_t state_next;
    logic   have_first_reg;
    logic   pending_close_reg;

    logic signed [COORD_W-1:0] first_x_reg;
    logic signed [COORD_W-1:0] first_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sy_reg;
    logic signed [COORD_W-1:0] ex_reg;
    logic signed [COORD_W-1:0] ey_reg;
    logic                      closing_reg;
    logic [DIFF_W-1:0]         ax_reg;
    logic [DIFF_W-1:0]         ay_reg;
    logic                      dy_neg_reg;
    logic                      dx_pos_reg;
    logic [ROOT_W-1:0]         len_reg;
    logic [ROOT_W-1:0]         qy_reg;
    logic signed [NORM_W-1:0]  nx_reg;
    logic signed [NORM_W-1:0]  ny_reg;
    logic signed [DIST_W-1:0]  dist_reg;
    logic                      degen_reg;

    logic                      in_fire;
    logic                      out_fire;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]         mag_or;
    logic [ROOT_W-1:0]         qy_c;
    logic [ROOT_W-1:0]         qx_c;
    logic signed [PROD_W-1:0]  dot_round;
    logic signed [PROD_W-1:0]  dot_shift;

    pesu_iter_ctrl_t           iter_ctrl;
    logic [PROD_W-1:0]         iter_operand;
    logic [ROOT_W-1:0]         iter_divisor;
    logic                      iter_done;
    logic [ROOT_W-1:0]         iter_result;

    pesu_mac_ctrl_t            mac_ctrl;
    logic signed [COORD_W-1:0] mac_a;
    logic signed [COORD_W-1:0] mac_b;
    logic                      mac_done;
    logic signed [PROD_W-1:0]  mac_acc;

    logic                      degen_zero;
    logic                      normals_bounded;

    assign vertex.ready = (state_reg == S_IDLE);
    assign in_fire      = vertex.valid && vertex.ready;
    assign out_fire     = plane.valid && plane.ready;

    // Edge differences and their magnitudes
    assign dx     = DIFF_W'(ex_reg) - DIFF_W'(sx_reg);
    assign dy     = DIFF_W'(ey_reg) - DIFF_W'(sy_reg);
    assign mag_or = ax_reg | ay_reg;

    // Clamp quotients to one
    assign qy_c = (qy_reg > NORM_ONE) ? NORM_ONE : qy_reg;
    assign qx_c = (iter_result > NORM_ONE) ? NORM_ONE : iter_result;

    // Distance rounding: half toward plus infinity
    assign dot_round = mac_acc + ROUND_HALF;
    assign dot_shift = dot_round >>> NORMAL_FRAC_BITS;

    // Shared unit requests
    always_comb
    begin
        iter_ctrl.start = 1'b0;
        iter_ctrl.op    = OP_SQRT;
        iter_operand    = mac_acc;
        iter_divisor    = len_reg;
        case (state_reg)
            S_SQW:
            begin
                iter_ctrl.start = mac_done;
            end
            S_SQRT:
            begin
                iter_ctrl.start = iter_done;
                iter_ctrl.op    = OP_DIV;
                iter_operand    = (PROD_W'(ay_reg[ROOT_W-2:0]) << NORMAL_FRAC_BITS)
                                + PROD_W'(iter_result[ROOT_W-1:1]);
                iter_divisor    = iter_result;
            end
            S_DIVY:
            begin
                iter_ctrl.start = iter_done;
                iter_ctrl.op    = OP_DIV;
                iter_operand    = (PROD_W'(ax_reg[ROOT_W-2:0]) << NORMAL_FRAC_BITS)
                                + PROD_W'(len_reg[ROOT_W-1:1]);
            end
            default:
            begin
                iter_ctrl.start = 1'b0;
            end
        endcase
    end

    // Multiplier requests: squares of the magnitudes, then the dot product
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = COORD_W'(ax_reg);
        mac_b    = COORD_W'(ax_reg);
        case (state_reg)
            S_SQA:
            begin
                mac_ctrl.valid = 1'b1;
                mac_ctrl.first = 1'b1;
            end
            S_SQB:
            begin
                mac_ctrl.valid = 1'b1;
                mac_ctrl.last  = 1'b1;
                mac_a          = COORD_W'(ay_reg);
                mac_b          = COORD_W'(ay_reg);
            end
            S_DOTA:
            begin
                mac_ctrl.valid = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_a          = sx_reg;
                mac_b          = nx_reg;
            end
            S_DOTB:
            begin
                mac_ctrl.valid = 1'b1;
                mac_ctrl.last  = 1'b1;
                mac_a          = sy_reg;
                mac_b          = ny_reg;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (have_first_reg || vertex.last_vertex))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                state_next = ((dx == '0) && (dy == '0)) ? S_OUT : S_NORM;
            end
            S_NORM:
            begin
                if ((mag_or[DIFF_W-1:ROOT_W-1] == '0) && mag_or[ROOT_W-2])
                begin
                    state_next = S_SQA;
                end
            end
            S_SQA:  state_next = S_SQB;
            S_SQB:  state_next = S_SQW;
            S_SQW:
            begin
                if (mac_done)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (iter_done)
                begin
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (iter_done)
                begin
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (iter_done)
                begin
                    state_next = S_DOTA;
                end
            end
            S_DOTA: state_next = S_DOTB;
            S_DOTB: state_next = S_DOTW;
            S_DOTW:
            begin
                if (mac_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = pending_close_reg ? S_DIFF : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer and polygon tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            have_first_reg    <= 1'b0;
            pending_close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                have_first_reg    <= !vertex.last_vertex;
                pending_close_reg <= have_first_reg && vertex.last_vertex;
            end
            else if (out_fire && pending_close_reg)
            begin
                pending_close_reg <= 1'b0;
            end
        end
    end

    // Vertex storage and edge endpoints
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prev_x_reg <= vertex.vertex_x;
            prev_y_reg <= vertex.vertex_y;
            ex_reg     <= vertex.vertex_x;
            ey_reg     <= vertex.vertex_y;
            if (!have_first_reg)
            begin
                first_x_reg <= vertex.vertex_x;
                first_y_reg <= vertex.vertex_y;
                sx_reg      <= vertex.vertex_x;
                sy_reg      <= vertex.vertex_y;
                closing_reg <= 1'b1;
            end
            else
            begin
                sx_reg      <= prev_x_reg;
                sy_reg      <= prev_y_reg;
                closing_reg <= 1'b0;
            end
        end
        else if (out_fire && pending_close_reg)
        begin
            // Closing edge runs from the last vertex back to the first
            sx_reg      <= prev_x_reg;
            sy_reg      <= prev_y_reg;
            ex_reg      <= first_x_reg;
            ey_reg      <= first_y_reg;
            closing_reg <= 1'b1;
        end
    end

    // Edge datapath: magnitudes, normalization, quotients, results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_DIFF:
            begin
                ax_reg     <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
                ay_reg     <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
                dy_neg_reg <= dy[DIFF_W-1];
                dx_pos_reg <= !dx[DIFF_W-1] && (dx != '0);
                degen_reg  <= (dx == '0) && (dy == '0);
                nx_reg     <= '0;
                ny_reg     <= '0;
                dist_reg   <= '0;
            end
            S_NORM:
            begin
                if (mag_or[DIFF_W-1:ROOT_W-1] != '0)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (mag_or[ROOT_W-2:ROOT_W-9] == '0)
                begin
                    ax_reg <= ax_reg << 8;
                    ay_reg <= ay_reg << 8;
                end
                else if (!mag_or[ROOT_W-2])
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            end
            S_SQRT:
            begin
                if (iter_done)
                begin
                    len_reg <= iter_result;
                end
            end
            S_DIVY:
            begin
                if (iter_done)
                begin
                    qy_reg <= iter_result;
                end
            end
            S_DIVX:
            begin
                if (iter_done)
                begin
                    nx_reg <= dy_neg_reg ? -$signed(qy_c) : $signed(qy_c);
                    ny_reg <= dx_pos_reg ? -$signed(qx_c) : $signed(qx_c);
                end
            end
            S_DOTW:
            begin
                if (mac_done)
                begin
                    dist_reg <= dot_shift[DIST_W-1:0];
                end
            end
            default:
            begin
                degen_reg <= degen_reg;
            end
        endcase
    end

    pesu_iter_unit #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (iter_ctrl),
        .operand (iter_operand),
        .divisor (iter_divisor),
        .done    (iter_done),
        .result  (iter_result)
    );

    pesu_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    // Result channel
    assign plane.valid           = (state_reg == S_OUT);
    assign plane.normal_x        = nx_reg;
    assign plane.normal_y        = ny_reg;
    assign plane.plane_distance  = dist_reg;
    assign plane.degenerate_edge = degen_reg;
    assign plane.last_plane      = closing_reg;

    // Check terms
    assign degen_zero      = (plane.normal_x == '0) && (plane.normal_y == '0)
                           && (plane.plane_distance == '0);
    assign normals_bounded = ($signed(plane.normal_x) <= $signed(NORM_ONE))
                           && ($signed(plane.normal_x) >= -$signed(NORM_ONE))
                           && ($signed(plane.normal_y) <= $signed(NORM_ONE))
                           && ($signed(plane.normal_y) >= -$signed(NORM_ONE));

    // Checks
    `PESU_ASSERT_SAME(a_no_accept_while_pending, clk, rst_n, plane.valid, !vertex.ready)
    `PESU_ASSERT_SAME(a_degenerate_zero, clk, rst_n, plane.valid && plane.degenerate_edge, degen_zero)
    `PESU_ASSERT_SAME(a_normal_bounded, clk, rst_n, plane.valid, normals_bounded)
    `PESU_ASSERT_NEXT(a_close_follows, clk, rst_n, out_fire && pending_close_reg, state_reg == S_DIFF)

endmodule

// ===== test/tb_polygon_edge_plane_setup_unit.sv =====
// Testbench for polygon_edge_plane_setup_unit: streams polygon vertices and checks each
// edge half-plane against a bit-exact fixed-point predictor held in a small scoreboard.
// Depends on pesu_pkg, pesu_vertex_if, pesu_plane_if and the block itself.
`timescale 1ns / 1ps

module tb_polygon_edge_plane_setup_unit;
    import pesu_pkg::*;

    localparam int NFB          = 30;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int TAIL_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 1750;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;

    // Coordinate classes for random polygons
    typedef enum int
    {
        CM_FULL,
        CM_NEAR,
        CM_EXTREME,
        CM_TINY
    } coord_mode_t;

    typedef struct packed
    {
        logic [NORM_W-1:0] normal_x;
        logic [NORM_W-1:0] normal_y;
        logic [DIST_W-1:0] plane_distance;
        logic              degenerate_edge;
        logic              last_plane;
    } plane_t;

    // Polygon state tracker and expected plane store
    class plane_scoreboard;
        logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
        bit                        holding_first;
        plane_t                    expected_planes[$];
        int                        mismatches;

        function new();
            first_x       = '0;
            first_y       = '0;
            prev_x        = '0;
            prev_y        = '0;
            holding_first = 1'b0;
            mismatches    = 0;
        endfunction

        function int pending();
            return expected_planes.size();
        endfunction

        // Append one expected plane at the tail
        function void queue_plane(plane_t p);
            expected_planes.insert(expected_planes.size(), p);
        endfunction

        // Integer square root, bit by bit
        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned r, bitv;
            r    = 0;
            bitv = 64'd1 << 62;
            while (bitv > s)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (s >= r + bitv)
                begin
                    s = s - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else
                begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            return r;
        endfunction

        // Half-plane of the edge from start to end point
        function plane_t edge_plane(longint sx, longint sy, longint ex, longint ey,
                                    bit closing);
            longint          dx, dy, nx, ny, p, dist_q;
            longint unsigned ax, ay, mx, len, qx, qy, one;
            plane_t          r;
            r            = '0;
            r.last_plane = closing;
            dx = ex - sx;
            dy = ey - sy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            mx = (ax > ay) ? ax : ay;
            if (mx == 0)
            begin
                r.degenerate_edge = 1'b1;
                return r;
            end
            // Normalize so the larger magnitude lies in [2^30, 2^31)
            while (mx >= (64'd1 << 31))
            begin
                ax = ax >> 1;
                ay = ay >> 1;
                mx = mx >> 1;
            end
            while (mx < (64'd1 << 30))
            begin
                ax = ax << 1;
                ay = ay << 1;
                mx = mx << 1;
            end
            one = 64'd1 << NFB;
            len = int_sqrt(ax * ax + ay * ay);
            qy  = (ay * one + (len >> 1)) / len;
            qx  = (ax * one + (len >> 1)) / len;
            if (qy > one)
                qy = one;
            if (qx > one)
                qx = one;
            nx     = (dy < 0) ? -longint'(qy) : longint'(qy);
            ny     = (dx > 0) ? -longint'(qx) : longint'(qx);
            p      = sx * nx + sy * ny;
            dist_q = (p + (longint'(1) <<< (NFB - 1))) >>> NFB;
            r.normal_x       = nx[NORM_W-1:0];
            r.normal_y       = ny[NORM_W-1:0];
            r.plane_distance = dist_q[DIST_W-1:0];
            return r;
        endfunction

        // Advance polygon state on an accepted vertex and queue its planes
        function void note_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                  logic last);
            if (!holding_first)
            begin
                first_x = x;
                first_y = y;
                prev_x  = x;
                prev_y  = y;
                if (last)
                    queue_plane(edge_plane(x, y, x, y, 1'b1));
                else
                    holding_first = 1'b1;
                return;
            end
            queue_plane(edge_plane(prev_x, prev_y, x, y, 1'b0));
            prev_x = x;
            prev_y = y;
            if (last)
            begin
                queue_plane(edge_plane(x, y, first_x, first_y, 1'b1));
                holding_first = 1'b0;
            end
        endfunction

        // Compare an accepted plane with the oldest expectation
        function void check_plane(plane_t got);
            plane_t want;
            if (expected_planes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected plane: nx=%0d ny=%0d d=%0d deg=%0b last=%0b",
                             $signed(got.normal_x), $signed(got.normal_y),
                             $signed(got.plane_distance), got.degenerate_edge, got.last_plane);
                return;
            end
            want = expected_planes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("plane mismatch: exp nx=%0d ny=%0d d=%0d deg=%0b last=%0b",
                             $signed(want.normal_x), $signed(want.normal_y),
                             $signed(want.plane_distance), want.degenerate_edge,
                             want.last_plane);
                    $display("                got nx=%0d ny=%0d d=%0d deg=%0b last=%0b",
                             $signed(got.normal_x), $signed(got.normal_y),
                             $signed(got.plane_distance), got.degenerate_edge, got.last_plane);
                end
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      vtx_valid = 1'b0;
    logic signed [COORD_W-1:0] vtx_x     = '0;
    logic signed [COORD_W-1:0] vtx_y     = '0;
    logic                      vtx_last  = 1'b0;
    logic                      pln_ready = 1'b0;

    pesu_vertex_if vertex_ch ();
    pesu_plane_if  plane_ch ();

    assign vertex_ch.valid       = vtx_valid;
    assign vertex_ch.vertex_x    = vtx_x;
    assign vertex_ch.vertex_y    = vtx_y;
    assign vertex_ch.last_vertex = vtx_last;
    assign plane_ch.ready        = pln_ready;

    polygon_edge_plane_setup_unit #(
        .NORMAL_FRAC_BITS (NFB)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .plane  (plane_ch)
    );

    plane_scoreboard sb = new();

    int burst_left = 0;
    int items_sent = 0;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watch both channels: note accepted vertices, check accepted planes
    always @(posedge clk)
    begin
        if (rst_n && vertex_ch.valid && vertex_ch.ready)
            sb.note_vertex(vertex_ch.vertex_x, vertex_ch.vertex_y, vertex_ch.last_vertex);
        if (rst_n && plane_ch.valid && plane_ch.ready)
            sb.check_plane({plane_ch.normal_x, plane_ch.normal_y, plane_ch.plane_distance,
                            plane_ch.degenerate_edge, plane_ch.last_plane});
    end

    // Receiver back-pressure: phases of always-ready, rotating pattern, light and heavy stall
    int          rdy_mode    = 0;
    int          rdy_left    = 0;
    logic [31:0] rdy_pattern = '1;

    always @(posedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode    = $urandom_range(0, 3);
            rdy_left    = $urandom_range(16, 200);
            rdy_pattern = $urandom;
        end
        rdy_left--;
        case (rdy_mode)
            0: pln_ready <= 1'b1;
            1:
            begin
                rdy_pattern = {rdy_pattern[30:0], rdy_pattern[31]};
                pln_ready <= rdy_pattern[0];
            end
            2: pln_ready <= ($urandom_range(0, 3) != 0);
            default: pln_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Give up on a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Offer one vertex request, with bursts and idle gaps between them
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            end
            if (gap > 0)
            begin
                vtx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        vtx_valid <= 1'b1;
        vtx_x     <= x;
        vtx_y     <= y;
        vtx_last  <= last;
        @(posedge clk);
        while (!vertex_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every expected plane has come back
    task automatic drain_planes();
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(coord_mode_t mode,
                                                            logic signed [COORD_W-1:0] base);
        logic signed [COORD_W-1:0] v;
        case (mode)
            CM_FULL: v = $urandom;
            CM_NEAR: v = base + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            CM_EXTREME:
            begin
                case ($urandom_range(0, 5))
                    0: v = C_MIN;
                    1: v = C_MAX;
                    2: v = '0;
                    3: v = -1;
                    4: v = 1;
                    default: v = $urandom;
                endcase
            end
            default: v = base + $signed($urandom_range(0, 8)) - 4;
        endcase
        return v;
    endfunction

    // Random polygon of random size; sometimes repeat a vertex or end early
    task automatic send_random_polygon();
        int                        count;
        coord_mode_t               mode;
        logic signed [COORD_W-1:0] cx, cy, x, y;
        logic                      last;
        case ($urandom_range(0, 9))
            0: count = 1;
            1: count = 2;
            2: count = $urandom_range(7, 10);
            default: count = $urandom_range(3, 6);
        endcase
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: mode = CM_FULL;
            5, 6: mode = CM_EXTREME;
            7, 8, 9, 10, 11: mode = CM_TINY;
            default: mode = CM_NEAR;
        endcase
        cx = $urandom;
        cy = $urandom;
        x  = rand_coord(mode, cx);
        y  = rand_coord(mode, cy);
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && $urandom_range(0, 11) != 0)
            begin
                x = rand_coord(mode, cx);
                y = rand_coord(mode, cy);
            end
            last = (i == count - 1) || ($urandom_range(0, 31) == 0);
            send_vertex(x, y, last);
            if (last)
                break;
        end
    endtask

    initial
    begin
        // Hold reset, then release on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-vertex polygons
        send_vertex('0, '0, 1'b1);
        send_vertex(C_MIN, C_MAX, 1'b1);
        // Full-range triangle: edges wider than 32 bits
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b1);
        // Zero-length edge inside a polygon
        send_vertex(5 * C_ONE, 5 * C_ONE, 1'b0);
        send_vertex(5 * C_ONE, 5 * C_ONE, 1'b0);
        send_vertex('0, C_ONE, 1'b1);
        // Unit square
        send_vertex('0, '0, 1'b0);
        send_vertex(C_ONE, '0, 1'b0);
        send_vertex(C_ONE, C_ONE, 1'b0);
        send_vertex('0, C_ONE, 1'b1);
        // One-LSB diagonal edge
        send_vertex(32'sd1, '0, 1'b0);
        send_vertex('0, 32'sd1, 1'b1);
        // Two coincident vertices: both edges degenerate
        send_vertex(-32'sd1, -32'sd1, 1'b0);
        send_vertex(-32'sd1, -32'sd1, 1'b1);
        // Axis-aligned full-range edges
        send_vertex(C_MIN, '0, 1'b0);
        send_vertex(C_MAX, '0, 1'b1);
        send_vertex('0, C_MIN, 1'b0);
        send_vertex('0, C_MAX, 1'b1);
        // Pythagorean-triple edge
        send_vertex('0, '0, 1'b0);
        send_vertex(3 * C_ONE, 4 * C_ONE, 1'b1);
        drain_planes();

        // Random polygons, with an occasional full drain
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            send_random_polygon();
            if ($urandom_range(0, 39) == 0)
                drain_planes();
        end

        // Close any open polygon so its stored vertex is flushed too
        send_vertex($urandom, $urandom, 1'b1);
        drain_planes();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
